// ----- rtl/mspg_pkg.sv -----
// Shared package of the Morton stratified point generator.
// Holds the generator constants, reset values, register codes, item structs and
// the PCG32 and bit-gather helper functions. Depends on nothing.
package mspg_pkg;

   localparam int MAX_GRID_ORDER_DEF = 16;
   localparam int CSR_INDEX_W        = 4;
   localparam int COUNT_W            = 33;

   localparam logic [63:0] LCG_MULT          = 64'd6364136223846793005;
   localparam logic [4:0]  RESET_GRID_ORDER  = 5'd10;
   localparam logic [5:0]  RESET_POINT_ORDER = 6'd16;
   localparam logic [63:0] RESET_SEED        = 64'd0;
   localparam logic [63:0] RESET_STREAM      = 64'd12345;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_GRID_ORDER    = 4'd0,
      CSR_POINT_ORDER   = 4'd1,
      CSR_SEED_VALUE    = 4'd2,
      CSR_STREAM_SELECT = 4'd3
   } csr_addr_type;

   // Effective settings, the precomputed reseed state and increment, and the busy flag.
   typedef struct packed {
      logic [4:0]  grid;
      logic [5:0]  points;
      logic [63:0] reseed_state;
      logic [63:0] reseed_inc;
      logic        busy;
   } cfg_view_type;

   // One item between the generator stage and the mapping stage.
   typedef struct packed {
      logic               exhausted;
      logic [4:0]         grid;
      logic [5:0]         points;
      logic [31:0]        rnd;
      logic [COUNT_W-1:0] count;
   } item_type;

   // LCG step: constant multiply plus increment, low 64 bits.
   function automatic logic [63:0] lcg_step(input logic [63:0] state,
                                            input logic [63:0] inc);
      lcg_step = state * LCG_MULT + inc;
   endfunction

   // XSH-RR output of the old state.
   function automatic logic [31:0] pcg_output(input logic [63:0] old);
      logic [63:0] mixed;
      logic [31:0] xs;
      logic [4:0]  rot;
      logic [63:0] both;
      mixed = ((old >> 18) ^ old) >> 27;
      xs    = mixed[31:0];
      rot   = old[63:59];
      both  = {xs, xs} >> rot;
      pcg_output = both[31:0];
   endfunction

   // Even bits of a 32-bit word, packed.
   function automatic logic [15:0] gather_even(input logic [31:0] v);
      logic [15:0] r;
      for (int i = 0; i < 16; i++) begin
         r[i] = v[2*i];
      end
      gather_even = r;
   endfunction

   localparam logic [63:0] RESET_INC   = RESET_STREAM | 64'd1;
   localparam logic [63:0] RESET_STATE =
      lcg_step(lcg_step(64'd0, RESET_INC) + RESET_SEED, RESET_INC);

endpackage

// ----- rtl/morton_stratified_point_generator.sv -----
// Morton stratified point generator, top level.
// Depends on mspg_pkg, mspg_cfg, mspg_gen and mspg_map.
//
// One point per request item, one item per cycle sustained while the output
// takes results and no reseed is pending: the PCG32 step (a 64-bit constant
// multiply-add) sits in the generator stage and the Morton de-interleave in
// the mapping stage, so a result passes the item register and then the result
// register after its request is taken. After reset and after each write to
// seed_value or stream_select, req_tready stays low while the reseed state is
// precomputed through an add register and a constant multiply-add register.
module morton_stratified_point_generator #(
   parameter int MAX_GRID_ORDER = mspg_pkg::MAX_GRID_ORDER_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [7:0]                       req_tdata,  // [0] restart
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [95:0]                      rsp_tdata,  // x_coord, y_coord, bit_index,
                                                        // point_number
   output logic                             rsp_tlast,
   output logic                             rsp_tuser,  // exhausted
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [mspg_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [63:0]                      csr_data
);
   import mspg_pkg::*;

   cfg_view_type cfg;
   item_type     item;
   logic         item_valid;
   logic         stage_ready;

   mspg_cfg #(
      .MAX_GRID_ORDER(MAX_GRID_ORDER)
   ) u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   mspg_gen u_gen (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .req_restart (req_tdata[0]),
      .cfg         (cfg),
      .stage_ready (stage_ready),
      .item_valid  (item_valid),
      .item        (item)
   );

   mspg_map u_map (
      .clock         (clock),
      .reset         (reset),
      .item_valid    (item_valid),
      .item          (item),
      .stage_ready   (stage_ready),
      .rsp_valid     (rsp_tvalid),
      .rsp_ready     (rsp_tready),
      .rsp_data      (rsp_tdata),
      .rsp_last      (rsp_tlast),
      .rsp_exhausted (rsp_tuser)
   );

endmodule

// ----- rtl/mspg_cfg.sv -----
// Configuration registers, order clamping and reseed precompute.
// Depends on mspg_pkg.
module mspg_cfg #(
   parameter int MAX_GRID_ORDER = mspg_pkg::MAX_GRID_ORDER_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [mspg_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [63:0]                      csr_data,
   output mspg_pkg::cfg_view_type           cfg
);
   import mspg_pkg::*;

   logic [4:0]  grid_ff, grid_in;
   logic [5:0]  point_ff, point_in;
   logic [63:0] seed_ff, seed_in;
   logic [63:0] stream_ff, stream_in;
   logic [1:0]  busy_ff, busy_in;
   logic [63:0] base_ff, base_in;
   logic [63:0] reseed_ff, reseed_in;
   logic [63:0] inc_cfg;
   logic [4:0]  grid_eff;
   logic [5:0]  point_lo;
   logic [5:0]  point_cap;
   logic        csr_fire;

   assign csr_ready = 1'b1;
   assign csr_fire  = csr_valid && csr_ready;
   assign inc_cfg   = stream_ff | 64'd1;

   always_comb begin
      grid_in   = grid_ff;
      point_in  = point_ff;
      seed_in   = seed_ff;
      stream_in = stream_ff;
      busy_in   = (busy_ff != 2'd0) ? busy_ff - 2'd1 : 2'd0;
      if (csr_fire) begin
         case (csr_index)
            CSR_GRID_ORDER:  grid_in  = csr_data[4:0];
            CSR_POINT_ORDER: point_in = csr_data[5:0];
            CSR_SEED_VALUE: begin
               seed_in = csr_data;
               busy_in = 2'd2;
            end
            CSR_STREAM_SELECT: begin
               stream_in = csr_data;
               busy_in   = 2'd2;
            end
            default: ;
         endcase
      end
      base_in   = inc_cfg + seed_ff;
      reseed_in = lcg_step(base_ff, inc_cfg);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_ff   <= RESET_GRID_ORDER;
         point_ff  <= RESET_POINT_ORDER;
         seed_ff   <= RESET_SEED;
         stream_ff <= RESET_STREAM;
         busy_ff   <= 2'd2;
      end else begin
         grid_ff   <= grid_in;
         point_ff  <= point_in;
         seed_ff   <= seed_in;
         stream_ff <= stream_in;
         busy_ff   <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      base_ff   <= base_in;
      reseed_ff <= reseed_in;
   end

   always_comb begin
      if (grid_ff == 5'd0) begin
         grid_eff = 5'd1;
      end else if (grid_ff > 5'(MAX_GRID_ORDER)) begin
         grid_eff = 5'(MAX_GRID_ORDER);
      end else begin
         grid_eff = grid_ff;
      end
      point_lo  = (point_ff == 6'd0) ? 6'd1 : point_ff;
      point_cap = {grid_eff, 1'b0};
   end

   assign cfg.grid         = grid_eff;
   assign cfg.points       = (point_lo > point_cap) ? point_cap : point_lo;
   assign cfg.reseed_state = reseed_ff;
   assign cfg.reseed_inc   = inc_cfg;
   assign cfg.busy         = (busy_ff != 2'd0);

`ifndef ASSERT_OFF
   a_seed_write_busy: assert property (@(posedge clock) disable iff (reset)
      csr_fire && (csr_index == CSR_SEED_VALUE || csr_index == CSR_STREAM_SELECT)
      |=> cfg.busy ##1 cfg.busy)
      else $error("reseed precompute not held busy after seed write");
`endif

endmodule

// ----- rtl/mspg_gen.sv -----
// Generator stage: PCG32 state, point counter, restart and exhaustion.
// Depends on mspg_pkg.
module mspg_gen (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_restart,
   input  mspg_pkg::cfg_view_type cfg,
   input  logic                   stage_ready,
   output logic                   item_valid,
   output mspg_pkg::item_type     item
);
   import mspg_pkg::*;

   logic [63:0]        state_ff, state_in;
   logic [63:0]        inc_ff, inc_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               item_valid_ff, item_valid_in;
   item_type           item_ff, item_in;
   logic [63:0]        cur_state;
   logic [63:0]        cur_inc;
   logic [COUNT_W-1:0] cur_count;
   logic               exhausted;
   logic               accept;

   assign req_ready = (!item_valid_ff || stage_ready) && !cfg.busy;
   assign accept    = req_valid && req_ready;

   assign cur_state = req_restart ? cfg.reseed_state : state_ff;
   assign cur_inc   = req_restart ? cfg.reseed_inc : inc_ff;
   assign cur_count = req_restart ? '0 : count_ff;
   assign exhausted = (cur_count >> cfg.points) != '0;

   always_comb begin
      state_in      = state_ff;
      inc_in        = inc_ff;
      count_in      = count_ff;
      item_in       = item_ff;
      item_valid_in = item_valid_ff && !stage_ready;
      if (accept) begin
         item_valid_in     = 1'b1;
         item_in.exhausted = exhausted;
         item_in.grid      = cfg.grid;
         item_in.points    = cfg.points;
         item_in.rnd       = pcg_output(cur_state);
         item_in.count     = cur_count;
         if (!exhausted) begin
            state_in = lcg_step(cur_state, cur_inc);
            inc_in   = cur_inc;
            count_in = cur_count + COUNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= RESET_STATE;
         inc_ff        <= RESET_INC;
         count_ff      <= '0;
         item_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         inc_ff        <= inc_in;
         count_ff      <= count_in;
         item_valid_ff <= item_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   assign item_valid = item_valid_ff;
   assign item       = item_ff;

`ifndef ASSERT_OFF
   a_restart_count: assert property (@(posedge clock) disable iff (reset)
      accept && req_restart |=> count_ff == COUNT_W'(1))
      else $error("counter not at one after restart item");

   a_exhausted_hold: assert property (@(posedge clock) disable iff (reset)
      accept && exhausted |=> $stable(state_ff) && $stable(count_ff))
      else $error("generator moved on exhausted item");
`endif

endmodule

// ----- rtl/mspg_map.sv -----
// Mapping stage: Morton code build, de-interleave, bitmap index, result register.
// Depends on mspg_pkg.
module mspg_map (
   input  logic               clock,
   input  logic               reset,
   input  logic               item_valid,
   input  mspg_pkg::item_type item,
   output logic               stage_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [95:0]        rsp_data,
   output logic               rsp_last,
   output logic               rsp_exhausted
);
   import mspg_pkg::*;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [95:0]        rsp_data_ff, rsp_data_in;
   logic               rsp_last_ff, rsp_last_in;
   logic               rsp_exh_ff, rsp_exh_in;
   logic [5:0]         shift;
   logic [31:0]        mask;
   logic [COUNT_W-1:0] cnt_sh;
   logic [31:0]        code;
   logic [15:0]        x_coord;
   logic [15:0]        y_coord;
   logic [31:0]        bit_index;
   logic [COUNT_W-1:0] last_count;

   assign stage_ready = !rsp_valid_ff || rsp_ready;

   always_comb begin
      shift      = {item.grid, 1'b0} - item.points;
      mask       = (32'd1 << shift[4:0]) - 32'd1;
      cnt_sh     = item.count << shift;
      code       = (item.rnd & mask) | cnt_sh[31:0];
      x_coord    = gather_even(code);
      y_coord    = gather_even({1'b0, code[31:1]});
      bit_index  = ({16'd0, x_coord} << item.grid) + {16'd0, y_coord};
      last_count = (COUNT_W'(1) << item.points) - COUNT_W'(1);

      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_exh_in   = rsp_exh_ff;
      if (item_valid && stage_ready) begin
         rsp_valid_in = 1'b1;
         rsp_exh_in   = item.exhausted;
         if (item.exhausted) begin
            rsp_data_in = '0;
            rsp_last_in = 1'b0;
         end else begin
            rsp_data_in = {item.count[31:0], bit_index, y_coord, x_coord};
            rsp_last_in = (item.count == last_count);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
      rsp_exh_ff  <= rsp_exh_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_data      = rsp_data_ff;
   assign rsp_last      = rsp_last_ff;
   assign rsp_exhausted = rsp_exh_ff;

`ifndef ASSERT_OFF
   a_exhausted_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_exh_ff |-> rsp_data_ff == '0 && !rsp_last_ff)
      else $error("exhausted item carries data");
`endif

endmodule

// ----- dv/morton_stratified_point_generator_test.sv -----
// Testbench of morton_stratified_point_generator: sends point requests and
// register writes, and checks each point against its own PCG32 and Morton model.
// Depends on mspg_pkg and the RTL of the block.
module morton_stratified_point_generator_test;
   import mspg_pkg::*;

   localparam logic [63:0] PCG_MULT = 64'd6364136223846793005;
   localparam int GRID_CAP = 16;
   localparam logic [CSR_INDEX_W-1:0] CSR_NO_REG = 4'hf;
   localparam int CYCLE_LIMIT = 400000;
   localparam int RANDOM_ITEMS = 1250;
   localparam int QUIET_ITEMS = 150;
   localparam int DRAIN_CYCLES = 8;
   localparam int HOLD_OFF_CYCLES = 300;

   typedef struct packed {
      logic [15:0] x_coord;
      logic [15:0] y_coord;
      logic [31:0] bit_index;
      logic [31:0] point_number;
      logic        last;
      logic        exhausted;
   } point_type;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [7:0]             req_tdata;   // [0] restart
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [95:0]            rsp_tdata;   // x_coord, y_coord, bit_index, point_number
   logic                   rsp_tlast;
   logic                   rsp_tuser;   // exhausted
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [63:0]            csr_data;

   // model state
   logic [4:0]  grid_reg;
   logic [5:0]  order_reg;
   logic [63:0] seed_reg;
   logic [63:0] stream_reg;
   logic [63:0] pcg_state;
   logic [63:0] pcg_inc;
   logic [32:0] point_count;
   point_type   points_due[$];

   int fail_count = 0;
   int cycle_count = 0;
   int items_sent = 0;
   bit idling_on = 1'b0;
   int hold_off_calls = 0;

   morton_stratified_point_generator i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // ---------------------------------------------------------------- model
   function automatic logic [31:0] pcg_draw();
      logic [63:0] prev;
      logic [31:0] xs;
      logic [4:0]  rot;
      prev = pcg_state;
      pcg_state = prev * PCG_MULT + pcg_inc;
      xs = 32'(((prev >> 18) ^ prev) >> 27);
      rot = prev[63:59];
      return (xs >> rot) | (xs << (5'd0 - rot));
   endfunction

   function automatic void pcg_reseed();
      pcg_state = '0;
      pcg_inc = stream_reg | 64'd1;
      void'(pcg_draw());
      pcg_state = pcg_state + seed_reg;
      void'(pcg_draw());
   endfunction

   function automatic logic [15:0] even_bits(input logic [31:0] w);
      logic [31:0] v;
      v = w & 32'h5555_5555;
      v = (v | (v >> 1)) & 32'h3333_3333;
      v = (v | (v >> 2)) & 32'h0f0f_0f0f;
      v = (v | (v >> 4)) & 32'h00ff_00ff;
      v = (v | (v >> 8)) & 32'h0000_ffff;
      return v[15:0];
   endfunction

   function automatic int eff_grid();
      int g;
      g = grid_reg;
      if (g < 1) g = 1;
      if (g > GRID_CAP) g = GRID_CAP;
      return g;
   endfunction

   function automatic int eff_point_order();
      int p;
      p = order_reg;
      if (p < 1) p = 1;
      if (p > 2 * eff_grid()) p = 2 * eff_grid();
      return p;
   endfunction

   function automatic void store_register(input logic [CSR_INDEX_W-1:0] index,
                                          input logic [63:0] value);
      case (index)
         CSR_GRID_ORDER:    grid_reg = value[4:0];
         CSR_POINT_ORDER:   order_reg = value[5:0];
         CSR_SEED_VALUE:    seed_reg = value;
         CSR_STREAM_SELECT: stream_reg = value;
         default: ;
      endcase
   endfunction

   function automatic void reset_model();
      grid_reg = RESET_GRID_ORDER;
      order_reg = RESET_POINT_ORDER;
      seed_reg = RESET_SEED;
      stream_reg = RESET_STREAM;
      pcg_reseed();
      point_count = '0;
   endfunction

   function automatic void predict_point(input logic restart);
      int          g;
      int          p;
      int          shift;
      logic [63:0] total;
      logic [63:0] mask;
      logic [63:0] code;
      logic [31:0] code32;
      point_type   r;
      g = eff_grid();
      p = eff_point_order();
      if (restart) begin
         pcg_reseed();
         point_count = '0;
      end
      total = 64'd1 << p;
      r = '0;
      if ({31'd0, point_count} >= total) begin
         r.exhausted = 1'b1;
      end else begin
         shift = 2 * g - p;
         mask = (64'd1 << shift) - 64'd1;
         code = ({32'd0, pcg_draw()} & mask) | ({31'd0, point_count} << shift);
         code32 = code[31:0];
         r.x_coord = even_bits(code32);
         r.y_coord = even_bits(code32 >> 1);
         r.bit_index = ({16'd0, r.x_coord} << g) + {16'd0, r.y_coord};
         r.point_number = point_count[31:0];
         r.last = ({31'd0, point_count} == total - 64'd1);
         point_count = point_count + 33'd1;
      end
      points_due.push_back(r);
   endfunction

   // ---------------------------------------------------------- result side
   function automatic void compare_field(input string name, input logic [31:0] want,
                                         input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin : rsp_side
      point_type want;
      logic      ready_next;
      int        stall_left;
      int        hold_left;
      int        hold_seen;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (points_due.size() == 0) begin
            $error("point item with no expectation waiting");
            fail_count++;
         end else begin
            want = points_due.pop_front();
            compare_field("x_coord", 32'(want.x_coord), 32'(rsp_tdata[15:0]));
            compare_field("y_coord", 32'(want.y_coord), 32'(rsp_tdata[31:16]));
            compare_field("bit_index", want.bit_index, rsp_tdata[63:32]);
            compare_field("point_number", want.point_number, rsp_tdata[95:64]);
            compare_field("last", 32'(want.last), 32'(rsp_tlast));
            compare_field("exhausted", 32'(want.exhausted), 32'(rsp_tuser));
         end
      end
      if (hold_seen != hold_off_calls) begin
         hold_seen = hold_off_calls;
         hold_left = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         ready_next = 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         ready_next = 1'b0;
      end else if (idling_on && $urandom_range(7) == 0) begin
         stall_left = $urandom_range(10, 1) - 1;
         ready_next = 1'b0;
      end else begin
         ready_next = 1'b1;
      end
      rsp_tready <= ready_next;
   end

   // ---------------------------------------------------------- drive side
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (points_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_W-1:0] index,
                                 input logic [63:0] value);
      wait_idle();
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      store_register(index, value);
      csr_valid <= 1'b0;
   endtask

   task automatic send_point(input logic restart);
      if (idling_on && $urandom_range(3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(10, 1)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {7'd0, restart};
      do @(posedge clock); while (!req_tready);
      predict_point(restart);
      items_sent++;
   endtask

   // ---------------------------------------------------------------- tests
   task automatic test_reset_settings();
      send_point(1'b0);
      send_point(1'b0);
      send_point(1'b1);
   endtask

   task automatic test_order_clamps();
      // zero orders act as one: two points, then exhaustion
      write_register(CSR_GRID_ORDER, 64'd0);
      write_register(CSR_POINT_ORDER, 64'd0);
      send_point(1'b1);
      send_point(1'b0);
      send_point(1'b0);
      // oversize orders clamp to the largest grid
      write_register(CSR_GRID_ORDER, 64'd31);
      write_register(CSR_POINT_ORDER, 64'd63);
      send_point(1'b0);
      send_point(1'b1);
      // full grid, no random bits
      write_register(CSR_GRID_ORDER, 64'd1);
      write_register(CSR_POINT_ORDER, 64'd2);
      send_point(1'b1);
      repeat (4) send_point(1'b0);
   endtask

   task automatic test_seed_extremes();
      write_register(CSR_GRID_ORDER, 64'd16);
      write_register(CSR_POINT_ORDER, 64'd1);
      write_register(CSR_SEED_VALUE, '1);
      write_register(CSR_STREAM_SELECT, '1);
      send_point(1'b0);
      send_point(1'b1);
      send_point(1'b0);
      send_point(1'b0);
      write_register(CSR_SEED_VALUE, '0);
      write_register(CSR_STREAM_SELECT, '0);
      send_point(1'b1);
      write_register(CSR_NO_REG, '1);
      send_point(1'b0);
   endtask

   task automatic test_midrun_order_change();
      write_register(CSR_GRID_ORDER, 64'd4);
      write_register(CSR_POINT_ORDER, 64'd8);
      send_point(1'b1);
      send_point(1'b0);
      send_point(1'b0);
      write_register(CSR_POINT_ORDER, 64'd1);
      send_point(1'b0);
      write_register(CSR_POINT_ORDER, 64'd8);
      send_point(1'b0);
   endtask

   task automatic test_output_backpressure();
      write_register(CSR_GRID_ORDER, 64'd8);
      write_register(CSR_POINT_ORDER, 64'd12);
      hold_off_calls++;
      send_point(1'b1);
      repeat (40) send_point(1'b0);
   endtask

   task automatic random_settings();
      if ($urandom_range(4) == 0) write_register(CSR_GRID_ORDER, 64'($urandom_range(31)));
      else write_register(CSR_GRID_ORDER, 64'($urandom_range(4, 1)));
      if ($urandom_range(4) == 0) write_register(CSR_POINT_ORDER, 64'($urandom_range(63)));
      else write_register(CSR_POINT_ORDER, 64'($urandom_range(6, 1)));
      if ($urandom_range(1)) write_register(CSR_SEED_VALUE, {$urandom, $urandom});
      if ($urandom_range(1)) write_register(CSR_STREAM_SELECT, {$urandom, $urandom});
      if ($urandom_range(7) == 0) begin
         write_register(CSR_INDEX_W'($urandom_range(15, 4)), {$urandom, $urandom});
      end
   endtask

   task automatic test_random_runs();
      int first;
      int run_len;
      first = items_sent;
      while (items_sent - first < RANDOM_ITEMS) begin
         idling_on = (items_sent - first < RANDOM_ITEMS - QUIET_ITEMS);
         random_settings();
         if (eff_point_order() <= 6) run_len = (1 << eff_point_order()) + $urandom_range(2);
         else run_len = $urandom_range(40, 1);
         // well-formed runs start with a restart, some continue the old run
         send_point($urandom_range(7) != 0);
         repeat (run_len) send_point($urandom_range(31) == 0);
      end
   endtask

   initial begin
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      csr_valid <= 1'b0;
      csr_index <= CSR_GRID_ORDER;
      csr_data <= '0;
      reset_model();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      idling_on = 1'b1;
      test_reset_settings();
      test_order_clamps();
      test_seed_extremes();
      test_midrun_order_change();
      idling_on = 1'b0;
      test_output_backpressure();
      test_random_runs();
      wait_idle();
      if (fail_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/mspg_pkg.sv
rtl/mspg_cfg.sv
rtl/mspg_gen.sv
rtl/mspg_map.sv
rtl/morton_stratified_point_generator.sv
dv/morton_stratified_point_generator_test.sv
